### sv/dq_pkg.sv
// Shared constants and types for the double-ended queue.
// Holds command and status codes and the chain operation type.
// No dependencies.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CH_IDLE,
        CH_PUSH_FRONT,
        CH_PUSH_BACK,
        CH_POP_FRONT,
        CH_ROTATE
    } t_chain_op;

endpackage

`default_nettype wire

### sv/double_ended_queue.sv
// Top level of the bounded double-ended queue: command decode, count and
// dump sequencing around a chain of dq_cell storage cells.
// Depends on dq_pkg and dq_cell.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+--------------------------
//  command   | i_command, i_value                           | start high, busy low
//  result    | o_word, o_status, o_final_item, o_occupancy  | o_result_valid, 1 cycle
//
// Push, pop and refused commands give their result in the cycle after
// the transaction and busy stays low, so commands may follow back to
// back. A dump of N held entries keeps busy high while it streams the
// entries out, one entry per cycle, as the cell chain rotates once
// around. Reset (i_rst_n low, synchronous) empties the queue; cell
// contents are left as they are. The receiver cannot stall results.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dq_pkg::CMD_W-1:0]      i_command,
    input  wire logic signed [dq_pkg::WORD_W-1:0] i_value,
    output logic                               o_result_valid,
    output logic signed [dq_pkg::WORD_W-1:0]   o_word,
    output logic      [dq_pkg::STAT_W-1:0]     o_status,
    output logic                               o_final_item,
    output logic      [dq_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state                      r_state,  n_state;
    logic [CW-1:0]               r_count,  n_count;
    logic [CW-1:0]               r_left,   n_left;
    logic                        r_valid,  n_valid;
    logic [dq_pkg::WORD_W-1:0]   r_word,   n_word;
    logic [dq_pkg::STAT_W-1:0]   r_status, n_status;
    logic                        r_final,  n_final;
    logic [dq_pkg::OCC_W-1:0]    r_occ,    n_occ;

    dq_pkg::t_chain_op           w_op;
    logic [dq_pkg::WORD_W-1:0]   w_cell_word [DEPTH];
    logic [DEPTH-1:0]            w_cell_last;
    logic [dq_pkg::WORD_W-1:0]   w_back_word;
    logic                        w_accept;

    // Cell chain: cell 0 holds the front entry, cell count-1 the back.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [dq_pkg::WORD_W-1:0] w_left;
        logic [dq_pkg::WORD_W-1:0] w_right;

        if (gi == 0) begin : g_head
            assign w_left = i_value;
        end else begin : g_body
            assign w_left = w_cell_word[gi-1];
        end

        if (gi == DEPTH-1) begin : g_tail
            assign w_right = w_cell_word[gi];
        end else begin : g_inner
            assign w_right = w_cell_word[gi+1];
        end

        dq_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_count (r_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_cell_word[0]),
            .o_word  (w_cell_word[gi]),
            .o_last  (w_cell_last[gi])
        );
    end

    // Pick the back entry: exactly one cell flags itself as last when not empty.
    always_comb begin
        w_back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_word = w_back_word | (w_cell_last[k] ? w_cell_word[k] : '0);
        end
    end

    assign busy     = (r_state == ST_DUMP);
    assign w_accept = start && !busy;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_valid  = 1'b0;
        n_word   = '0;
        n_status = dq_pkg::STAT_OK;
        n_final  = 1'b1;
        n_occ    = dq_pkg::OCC_W'(r_count);
        w_op     = dq_pkg::CH_IDLE;

        if (r_state == ST_DUMP) begin
            // emit the front entry and rotate it to the back
            n_valid = 1'b1;
            n_word  = w_cell_word[0];
            n_final = (r_left == ONE);
            w_op    = dq_pkg::CH_ROTATE;
            n_left  = r_left - ONE;
            if (r_left == ONE) n_state = ST_IDLE;
        end else if (w_accept) begin
            case (i_command)
                dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
                    n_valid = 1'b1;
                    if (r_count == FULL_COUNT) begin
                        n_status = dq_pkg::STAT_FULL;
                    end else begin
                        w_op    = (i_command == dq_pkg::CMD_PUSH_FRONT) ?
                                  dq_pkg::CH_PUSH_FRONT : dq_pkg::CH_PUSH_BACK;
                        n_count = r_count + ONE;
                        n_occ   = dq_pkg::OCC_W'(r_count + ONE);
                    end
                end
                dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
                    n_valid = 1'b1;
                    if (r_count == '0) begin
                        n_status = dq_pkg::STAT_EMPTY;
                    end else begin
                        if (i_command == dq_pkg::CMD_POP_FRONT) begin
                            n_word = w_cell_word[0];
                            w_op   = dq_pkg::CH_POP_FRONT;
                        end else begin
                            n_word = w_back_word;
                        end
                        n_count = r_count - ONE;
                        n_occ   = dq_pkg::OCC_W'(r_count - ONE);
                    end
                end
                dq_pkg::CMD_DUMP: begin
                    if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = dq_pkg::STAT_EMPTY;
                    end else begin
                        n_state = ST_DUMP;
                        n_left  = r_count;
                    end
                end
                default: begin
                    // drop unknown commands: no result, no state change
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_word   <= n_word;
        r_status <= n_status;
        r_final  <= n_final;
        r_occ    <= n_occ;
    end

    assign o_result_valid = r_valid;
    assign o_word         = r_word;
    assign o_status       = r_status;
    assign o_final_item   = r_final;
    assign o_occupancy    = r_occ;

endmodule

`default_nettype wire

### sv/dq_cell.sv
// One storage cell of the queue chain: holds one word and takes a new
// word from itself, a neighbor, the pushed value or the wrap path.
// Depends on dq_pkg.
`default_nettype none

module dq_cell #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                          i_clk,
    input  wire dq_pkg::t_chain_op             i_op,
    input  wire logic [$clog2(DEPTH+1)-1:0]    i_count,
    input  wire logic [dq_pkg::WORD_W-1:0]     i_value,
    input  wire logic [dq_pkg::WORD_W-1:0]     i_left,
    input  wire logic [dq_pkg::WORD_W-1:0]     i_right,
    input  wire logic [dq_pkg::WORD_W-1:0]     i_wrap,
    output logic      [dq_pkg::WORD_W-1:0]     o_word,
    output logic                               o_last
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

    logic [dq_pkg::WORD_W-1:0] r_word;
    logic [dq_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_op)
            dq_pkg::CH_PUSH_FRONT: n_word = i_left;
            dq_pkg::CH_PUSH_BACK: begin
                if (i_count == POS) n_word = i_value;
            end
            dq_pkg::CH_POP_FRONT: n_word = i_right;
            dq_pkg::CH_ROTATE: begin
                // back entry takes the front word, the rest move toward the front
                if (POS_NEXT == i_count) begin
                    n_word = i_wrap;
                end else if (POS_NEXT < i_count) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_last = (POS_NEXT == i_count);

endmodule

`default_nettype wire

### verif/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: random push, pop and dump
// traffic with sender gaps, checked against a behavioral deque in the bench.
// Depends on dq_pkg and the double_ended_queue RTL.
`default_nettype none

module tb_double_ended_queue;

    localparam int QDEPTH         = dq_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 2 * QDEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Commands above CMD_DUMP are undefined and must be dropped silently.
    localparam int CMD_MAX = (1 << dq_pkg::CMD_W) - 1;

    localparam logic signed [dq_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [dq_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    // Mix of the command stream in one random phase.
    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    typedef struct {
        logic [dq_pkg::CMD_W-1:0]         cmd;
        logic signed [dq_pkg::WORD_W-1:0] value;
        int                               gap;
    } t_deque_cmd;

    typedef struct {
        logic signed [dq_pkg::WORD_W-1:0] word;
        logic [dq_pkg::STAT_W-1:0]        status;
        logic                             final_item;
        logic [dq_pkg::OCC_W-1:0]         occupancy;
    } t_deque_reply;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic [dq_pkg::CMD_W-1:0]         i_command = dq_pkg::CMD_PUSH_FRONT;
    logic signed [dq_pkg::WORD_W-1:0] i_value = '0;
    logic                             busy;
    logic                             o_result_valid;
    logic signed [dq_pkg::WORD_W-1:0] o_word;
    logic [dq_pkg::STAT_W-1:0]        o_status;
    logic                             o_final_item;
    logic [dq_pkg::OCC_W-1:0]         o_occupancy;

    // Commands waiting to be driven, and replies the deque still owes us.
    t_deque_cmd   command_backlog[$];
    t_deque_reply replies_due[$];
    t_deque_cmd   next_cmd;

    // Bench copy of the deque: ring of words, front slot and fill level.
    logic signed [dq_pkg::WORD_W-1:0] ring_words[QDEPTH];
    int                               front_slot = 0;
    int                               held_count = 0;

    int queued_total   = 0;
    int accepted_total = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    wire cmd_taken = start && !busy;

    double_ended_queue #(
        .DEPTH(QDEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_result_valid (o_result_valid),
        .o_word         (o_word),
        .o_status       (o_status),
        .o_final_item   (o_final_item),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Carry a command out on the bench deque and queue the replies it owes.
    function automatic void carry_out_command(logic [dq_pkg::CMD_W-1:0] cmd,
                                              logic signed [dq_pkg::WORD_W-1:0] val);
        t_deque_reply r;
        r.word       = '0;
        r.status     = dq_pkg::STAT_OK;
        r.final_item = 1'b1;
        case (cmd)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
                if (held_count >= QDEPTH) begin
                    r.status = dq_pkg::STAT_FULL;
                end else if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
                    front_slot = (front_slot + QDEPTH - 1) % QDEPTH;
                    ring_words[front_slot] = val;
                    held_count++;
                end else begin
                    ring_words[(front_slot + held_count) % QDEPTH] = val;
                    held_count++;
                end
                r.occupancy = dq_pkg::OCC_W'(held_count);
                replies_due.push_back(r);
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
                if (held_count == 0) begin
                    r.status = dq_pkg::STAT_EMPTY;
                end else if (cmd == dq_pkg::CMD_POP_FRONT) begin
                    r.word = ring_words[front_slot];
                    front_slot = (front_slot + 1) % QDEPTH;
                    held_count--;
                end else begin
                    r.word = ring_words[(front_slot + held_count - 1) % QDEPTH];
                    held_count--;
                end
                r.occupancy = dq_pkg::OCC_W'(held_count);
                replies_due.push_back(r);
            end
            dq_pkg::CMD_DUMP: begin
                r.occupancy = dq_pkg::OCC_W'(held_count);
                if (held_count == 0) begin
                    r.status = dq_pkg::STAT_EMPTY;
                    replies_due.push_back(r);
                end else begin
                    // Stream front to back; flag only the back entry.
                    for (int i = 0; i < held_count; i++) begin
                        r.word       = ring_words[(front_slot + i) % QDEPTH];
                        r.final_item = (i == held_count - 1);
                        replies_due.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Sender gap before a command: mostly none, sometimes short, rarely long.
    function automatic int idle_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 9);
        else
            return $urandom_range(15, 40);
    endfunction

    // Payload word: extremes now and then, otherwise anything.
    function automatic logic signed [dq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_command(int cmd, logic signed [dq_pkg::WORD_W-1:0] val,
                                          int gap);
        t_deque_cmd c;
        c.cmd   = dq_pkg::CMD_W'(cmd);
        c.value = val;
        c.gap   = gap;
        command_backlog.push_back(c);
        queued_total++;
    endfunction

    task automatic check_field(string field, logic signed [dq_pkg::WORD_W-1:0] want,
                               logic signed [dq_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // Driver: record the transaction taken at this edge, then hold the
    // command while busy, or advance to the next one after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (cmd_taken) begin
                carry_out_command(i_command, i_value);
                accepted_total++;
            end
            if (!(start && busy)) begin
                if (command_backlog.size() == 0) begin
                    start <= 1'b0;
                end else if (command_backlog[0].gap != 0) begin
                    command_backlog[0].gap--;
                    start <= 1'b0;
                end else begin
                    next_cmd  = command_backlog.pop_front();
                    start     <= 1'b1;
                    i_command <= next_cmd.cmd;
                    i_value   <= next_cmd.value;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest reply owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (replies_due.size() == 0) begin
                $error("result with nothing owed: word %0d status %0d", o_word, o_status);
                error_count++;
            end else begin
                check_field("word", replies_due[0].word, o_word);
                check_field("status", replies_due[0].status, o_status);
                check_field("final_item", replies_due[0].final_item, o_final_item);
                check_field("occupancy", replies_due[0].occupancy, o_occupancy);
                void'(replies_due.pop_front());
            end
        end
    end

    // Watchdog: drop out when neither side has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || cmd_taken || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** double_ended_queue: FAILED **");
            $finish;
        end
    end

    initial begin
        int     counted;
        int     span;
        int     r;
        int     push_cut;
        bit     quiet;
        t_phase phase;

        counted = 0;

        // Directed: empty pops and dump, undefined commands, a fill with the
        // extreme words, refused pushes both ends, full dump, pops both ends.
        queue_command(dq_pkg::CMD_POP_FRONT, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_POP_BACK, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_DUMP, pick_word(), idle_gap(0));
        for (int c = dq_pkg::CMD_DUMP + 1; c <= CMD_MAX; c++)
            queue_command(c, pick_word(), idle_gap(0));
        for (int k = 0; k < QDEPTH; k++) begin
            queue_command(k[0] ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT,
                          (k == 0) ? WORD_MIN : (k == 1) ? WORD_MAX :
                          (k == 2) ? '0 : (k == 3) ? '1 : pick_word(),
                          idle_gap(0));
        end
        queue_command(dq_pkg::CMD_PUSH_FRONT, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_PUSH_BACK, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_DUMP, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_POP_FRONT, pick_word(), idle_gap(0));
        queue_command(dq_pkg::CMD_POP_BACK, pick_word(), idle_gap(0));

        // Random phases that swing the fill level between empty and full.
        while (counted < RANDOM_ITEMS) begin
            phase = t_phase'($urandom_range(0, 2));
            span  = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
            case (phase)
                PHASE_FILL:  push_cut = 75;
                PHASE_DRAIN: push_cut = 30;
                default:     push_cut = 55;
            endcase
            repeat (span) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    queue_command($urandom_range(dq_pkg::CMD_DUMP + 1, CMD_MAX),
                                  pick_word(), idle_gap(quiet));
                end else begin
                    if (r < 10)
                        queue_command(dq_pkg::CMD_DUMP, pick_word(), idle_gap(quiet));
                    else if (r < push_cut)
                        queue_command($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_BACK :
                                      dq_pkg::CMD_PUSH_FRONT,
                                      pick_word(), idle_gap(quiet));
                    else
                        queue_command($urandom_range(0, 1) ? dq_pkg::CMD_POP_BACK :
                                      dq_pkg::CMD_POP_FRONT,
                                      pick_word(), idle_gap(quiet));
                    counted++;
                end
            end
        end

        // Hold reset, then release it once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every command taken, every reply in, then a quiet tail.
        wait (accepted_total == queued_total);
        wait (replies_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/dq_pkg.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
verif/tb_double_ended_queue.sv
